FILE: rtl/lcd4_pkg.sv
// shared types, constants and helpers for the 4-bit character lcd controller
`timescale 1ns / 1ps

package lcd4_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // nibbles of the power-up sequence
    localparam logic [3:0] NIB_INIT_EIGHT = 4'h3;
    localparam logic [3:0] NIB_INIT_FOUR  = 4'h2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_INIT = 2'd1,
        OP_CMD  = 2'd2,
        OP_DATA = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_BUSY_CHECK = 3'd0,
        CFG_STROBE     = 3'd1,
        CFG_SETTLE     = 3'd2,
        CFG_POWER_UP   = 3'd3,
        CFG_GAP_LONG   = 3'd4,
        CFG_GAP_SHORT  = 3'd5,
        CFG_CLEAR_WAIT = 3'd6
    } t_cfg_reg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_POWER,
        PH_INIT_STROBE,
        PH_INIT_WAIT,
        PH_SETTLE,
        PH_POLL_HIGH1,
        PH_POLL_LOW1,
        PH_POLL_HIGH2,
        PH_POLL_LOW2,
        PH_HI_STROBE,
        PH_NIB_GAP,
        PH_LO_STROBE,
        PH_CLEAR
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic       busy_pin;
    } t_in_item;

    typedef struct packed {
        logic       pin_enable;
        logic       pin_select;
        logic       pin_read_write;
        logic [3:0] pin_nibble;
        logic       drive_bus;
        logic       idle;
        logic       rejected;
    } t_out_item;

    // classified item handed from the front to the back
    typedef struct packed {
        logic       is_tick;
        logic       is_init;
        logic       is_byte;
        logic       data_sel;
        logic [7:0] byte_value;
        logic       busy_pin;
    } t_work_item;

    typedef struct packed {
        logic                       valid;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_DATA_WIDTH-1:0]  data;
    } t_cfg_wr;

    // function set, display on, entry mode, clear
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h28;
            2'd1: b = 8'h0C;
            2'd2: b = 8'h06;
            2'd3: b = 8'h01;
        endcase
        return b;
    endfunction

    // loaded counts clip at the counter's top value
    function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [CFG_DATA_WIDTH-1:0] n);
        logic [31:0] wide;
        wide = 32'(n);
        if (wide > 32'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return wide[COUNT_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/lcd4_front.sv
// front end: takes items, decodes the operation and queues them for the sequencer
`timescale 1ns / 1ps

module lcd4_front import lcd4_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_in_item   i_in_item,
    output logic       o_full,
    output logic       o_item_valid,
    output t_work_item o_item,
    input  logic       i_take
);

    t_work_item r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_work_item w_class;
    logic       w_push_ok;
    logic       w_take_ok;

    always_comb begin
        w_class            = '0;
        w_class.byte_value = i_in_item.byte_value;
        w_class.busy_pin   = i_in_item.busy_pin;
        unique case (i_in_item.operation)
            OP_TICK: w_class.is_tick = 1'b1;
            OP_INIT: w_class.is_init = 1'b1;
            OP_CMD:  w_class.is_byte = 1'b1;
            OP_DATA: begin
                w_class.is_byte  = 1'b1;
                w_class.data_sel = 1'b1;
            end
            default: w_class.is_tick = 1'b1;
        endcase
    end

    assign o_full       = (r_count == 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_push_ok    = i_push && !o_full;
    assign w_take_ok    = i_take && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_take_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push_ok) - 2'(w_take_ok);
        end
    end

endmodule

FILE: rtl/lcd4_back.sv
// back end: timing sequencer for the lcd bus, config registers and result queue
`timescale 1ns / 1ps

module lcd4_back import lcd4_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_wr    i_cfg,
    input  logic       i_item_valid,
    input  t_work_item i_item,
    output logic       o_take,
    output logic       o_empty,
    output t_out_item  o_out_item,
    input  logic       i_pop
);

    // config registers
    logic        r_busy_check;
    logic [7:0]  r_strobe_ticks;
    logic [15:0] r_settle_ticks;
    logic [15:0] r_power_up_ticks;
    logic [15:0] r_gap_long_ticks;
    logic [15:0] r_gap_short_ticks;
    logic [15:0] r_clear_wait_ticks;

    // sequencer state
    t_phase                 r_phase,      n_phase;
    logic [COUNT_WIDTH-1:0] r_tick_count, n_tick_count;
    logic [7:0]             r_byte_hold,  n_byte_hold;
    logic                   r_select,     n_select;
    logic [2:0]             r_init_step,  n_init_step;
    logic                   r_enable,     n_enable;
    logic                   r_read,       n_read;
    logic [3:0]             r_nibble,     n_nibble;
    logic                   r_drive,      n_drive;
    logic                   r_busy_seen,  n_busy_seen;

    // result queue
    t_out_item r_rq [2];
    logic      r_rwr;
    logic      r_rrd;
    logic [1:0] r_rcount;

    logic w_pop_ok, w_fire;
    logic w_tick, w_req, w_reject, w_start_init, w_start_byte;
    logic w_done;
    logic [COUNT_WIDTH-1:0] w_cnt_dec;
    logic [COUNT_WIDTH-1:0] w_ld_strobe, w_ld_settle, w_ld_power, w_ld_long;
    logic [COUNT_WIDTH-1:0] w_ld_short, w_ld_clear;
    logic       w_aw_init, w_aw_end, w_aw_sel;
    logic [2:0] w_aw_step_nx;
    logic [7:0] w_aw_byte;
    t_phase     w_aw_phase;
    t_out_item  w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_check       <= 1'b0;
            r_strobe_ticks     <= 8'd1;
            r_settle_ticks     <= 16'd60;
            r_power_up_ticks   <= 16'd15000;
            r_gap_long_ticks   <= 16'd5000;
            r_gap_short_ticks  <= 16'd1000;
            r_clear_wait_ticks <= 16'd1600;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BUSY_CHECK: r_busy_check       <= i_cfg.data[0];
                CFG_STROBE:     r_strobe_ticks     <= i_cfg.data[7:0];
                CFG_SETTLE:     r_settle_ticks     <= i_cfg.data;
                CFG_POWER_UP:   r_power_up_ticks   <= i_cfg.data;
                CFG_GAP_LONG:   r_gap_long_ticks   <= i_cfg.data;
                CFG_GAP_SHORT:  r_gap_short_ticks  <= i_cfg.data;
                CFG_CLEAR_WAIT: r_clear_wait_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_pop_ok = i_pop && (r_rcount != 2'd0);
    assign w_fire   = i_item_valid && ((r_rcount != 2'd2) || w_pop_ok);
    assign o_take   = w_fire;

    assign w_tick       = w_fire && i_item.is_tick;
    assign w_req        = w_fire && !i_item.is_tick;
    assign w_reject     = w_req && (r_phase != PH_IDLE);
    assign w_start_init = w_req && (r_phase == PH_IDLE) && i_item.is_init;
    assign w_start_byte = w_req && (r_phase == PH_IDLE) && i_item.is_byte;

    assign w_done    = (r_tick_count <= COUNT_WIDTH'(1));
    assign w_cnt_dec = r_tick_count - COUNT_WIDTH'(1);

    assign w_ld_strobe = sat_count(CFG_DATA_WIDTH'(r_strobe_ticks));
    assign w_ld_settle = sat_count(r_settle_ticks);
    assign w_ld_power  = sat_count(r_power_up_ticks);
    assign w_ld_long   = sat_count(r_gap_long_ticks);
    assign w_ld_short  = sat_count(r_gap_short_ticks);
    assign w_ld_clear  = sat_count(r_clear_wait_ticks);

    // end of a busy wait: next init byte, the held byte, or the end of init
    assign w_aw_init    = r_init_step[2];
    assign w_aw_end     = (r_init_step == 3'd7);
    assign w_aw_step_nx = r_init_step + 3'd1;
    assign w_aw_byte    = w_aw_init ? init_byte(w_aw_step_nx[1:0]) : r_byte_hold;
    assign w_aw_sel     = w_aw_init ? 1'b0 : r_init_step[0];
    assign w_aw_phase   = (w_aw_init && w_aw_end) ? (r_busy_check ? PH_IDLE : PH_CLEAR)
                                                  : PH_HI_STROBE;

    always_comb begin
        n_phase = r_phase;
        if (w_start_init) begin
            n_phase = PH_POWER;
        end else if (w_start_byte) begin
            n_phase = r_busy_check ? PH_POLL_LOW2 : PH_SETTLE;
        end else if (w_tick) begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_POWER:       if (w_done) n_phase = PH_INIT_STROBE;
                PH_INIT_STROBE: if (w_done) n_phase = PH_INIT_WAIT;
                PH_INIT_WAIT: begin
                    if (w_done) begin
                        n_phase = (r_init_step < 3'd3) ? PH_INIT_STROBE : PH_HI_STROBE;
                    end
                end
                PH_SETTLE:      if (w_done) n_phase = w_aw_phase;
                PH_POLL_HIGH1:  if (w_done) n_phase = PH_POLL_LOW1;
                PH_POLL_LOW1:   n_phase = PH_POLL_HIGH2;
                PH_POLL_HIGH2:  if (w_done) n_phase = PH_POLL_LOW2;
                PH_POLL_LOW2:   n_phase = r_busy_seen ? PH_POLL_HIGH1 : w_aw_phase;
                PH_HI_STROBE:   if (w_done) n_phase = PH_NIB_GAP;
                PH_NIB_GAP:     n_phase = PH_LO_STROBE;
                PH_LO_STROBE: begin
                    if (w_done) begin
                        if (r_init_step[2]) begin
                            n_phase = r_busy_check ? PH_POLL_LOW2 : PH_SETTLE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_CLEAR:       if (w_done) n_phase = PH_IDLE;
                default:        n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        n_tick_count = r_tick_count;
        n_byte_hold  = r_byte_hold;
        n_select     = r_select;
        n_init_step  = r_init_step;
        n_enable     = r_enable;
        n_read       = r_read;
        n_nibble     = r_nibble;
        n_drive      = r_drive;
        n_busy_seen  = r_busy_seen;
        if (w_start_init) begin
            n_enable     = 1'b0;
            n_select     = 1'b0;
            n_read       = 1'b0;
            n_drive      = 1'b1;
            n_init_step  = 3'd0;
            n_tick_count = w_ld_power;
        end else if (w_start_byte) begin
            n_byte_hold = i_item.byte_value;
            n_init_step = i_item.data_sel ? 3'd1 : 3'd0;
            n_select    = 1'b0;
            n_enable    = 1'b0;
            if (r_busy_check) begin
                n_drive     = 1'b0;
                n_read      = 1'b1;
                n_busy_seen = 1'b1;
            end else begin
                n_read       = 1'b0;
                n_drive      = 1'b1;
                n_tick_count = w_ld_settle;
            end
        end else if (w_tick) begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_POWER: begin
                    if (w_done) begin
                        n_nibble     = NIB_INIT_EIGHT;
                        n_enable     = 1'b1;
                        n_tick_count = w_ld_strobe;
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_INIT_STROBE: begin
                    if (w_done) begin
                        n_enable     = 1'b0;
                        n_tick_count = (r_init_step == 3'd0) ? w_ld_long : w_ld_short;
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_INIT_WAIT: begin
                    if (w_done) begin
                        n_init_step  = w_aw_step_nx;
                        n_enable     = 1'b1;
                        n_tick_count = w_ld_strobe;
                        if (r_init_step < 3'd2) begin
                            n_nibble = NIB_INIT_EIGHT;
                        end else if (r_init_step == 3'd2) begin
                            n_nibble = NIB_INIT_FOUR;
                        end else begin
                            // last nibble done, first full byte follows
                            n_byte_hold = init_byte(2'd0);
                            n_select    = 1'b0;
                            n_nibble    = 4'(init_byte(2'd0) >> 4);
                        end
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_SETTLE: begin
                    if (w_done) begin
                        n_tick_count = '0;
                        if (w_aw_init && w_aw_end) begin
                            n_init_step = 3'd0;
                            if (!r_busy_check) begin
                                n_tick_count = w_ld_clear;
                            end
                        end else begin
                            n_init_step  = w_aw_init ? w_aw_step_nx : r_init_step;
                            n_byte_hold  = w_aw_byte;
                            n_select     = w_aw_sel;
                            n_read       = 1'b0;
                            n_nibble     = w_aw_byte[7:4];
                            n_enable     = 1'b1;
                            n_tick_count = w_ld_strobe;
                        end
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_POLL_HIGH1: begin
                    if (w_done) begin
                        n_busy_seen  = i_item.busy_pin;
                        n_enable     = 1'b0;
                        n_tick_count = '0;
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_POLL_LOW1: begin
                    n_enable     = 1'b1;
                    n_tick_count = w_ld_strobe;
                end
                PH_POLL_HIGH2: begin
                    if (w_done) begin
                        n_enable     = 1'b0;
                        n_tick_count = '0;
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_POLL_LOW2: begin
                    if (r_busy_seen) begin
                        n_enable     = 1'b1;
                        n_tick_count = w_ld_strobe;
                    end else begin
                        n_drive = 1'b1;
                        n_read  = 1'b0;
                        if (w_aw_init && w_aw_end) begin
                            n_init_step = 3'd0;
                            if (!r_busy_check) begin
                                n_tick_count = w_ld_clear;
                            end
                        end else begin
                            n_init_step  = w_aw_init ? w_aw_step_nx : r_init_step;
                            n_byte_hold  = w_aw_byte;
                            n_select     = w_aw_sel;
                            n_nibble     = w_aw_byte[7:4];
                            n_enable     = 1'b1;
                            n_tick_count = w_ld_strobe;
                        end
                    end
                end
                PH_HI_STROBE: begin
                    if (w_done) begin
                        n_enable     = 1'b0;
                        n_nibble     = r_byte_hold[3:0];
                        n_tick_count = '0;
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_NIB_GAP: begin
                    n_enable     = 1'b1;
                    n_tick_count = w_ld_strobe;
                end
                PH_LO_STROBE: begin
                    if (w_done) begin
                        n_enable     = 1'b0;
                        n_tick_count = '0;
                        if (r_init_step[2]) begin
                            if (r_busy_check) begin
                                n_drive     = 1'b0;
                                n_read      = 1'b1;
                                n_select    = 1'b0;
                                n_busy_seen = 1'b1;
                            end else begin
                                n_tick_count = w_ld_settle;
                            end
                        end
                    end else begin
                        n_tick_count = w_cnt_dec;
                    end
                end
                PH_CLEAR: begin
                    n_tick_count = w_done ? '0 : w_cnt_dec;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_result.pin_enable     = n_enable;
        w_result.pin_select     = n_select;
        w_result.pin_read_write = n_read;
        w_result.pin_nibble     = n_nibble;
        w_result.drive_bus      = n_drive;
        w_result.idle           = (n_phase == PH_IDLE);
        w_result.rejected       = w_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_byte_hold  <= 8'd0;
            r_select     <= 1'b0;
            r_init_step  <= 3'd0;
            r_enable     <= 1'b0;
            r_read       <= 1'b0;
            r_nibble     <= 4'd0;
            r_drive      <= 1'b1;
            r_busy_seen  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_byte_hold  <= n_byte_hold;
            r_select     <= n_select;
            r_init_step  <= n_init_step;
            r_enable     <= n_enable;
            r_read       <= n_read;
            r_nibble     <= n_nibble;
            r_drive      <= n_drive;
            r_busy_seen  <= n_busy_seen;
        end
    end

    // result queue
    assign o_empty    = (r_rcount == 2'd0);
    assign o_out_item = r_rq[r_rrd];

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rq[r_rwr] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwr    <= 1'b0;
            r_rrd    <= 1'b0;
            r_rcount <= 2'd0;
        end else begin
            if (w_fire) begin
                r_rwr <= ~r_rwr;
            end
            if (w_pop_ok) begin
                r_rrd <= ~r_rrd;
            end
            r_rcount <= r_rcount + 2'(w_fire) - 2'(w_pop_ok);
        end
    end

endmodule

FILE: rtl/char_lcd_4bit_interface_core.sv
// top level of the 4-bit character lcd controller
`timescale 1ns / 1ps

// Controller for an HD44780-style character display on a 4-bit bus. Every
// item pushed in is either a one-microsecond tick (operation 0), a start of
// initialisation (1), a command byte (2) or a data byte (3); each item yields
// exactly one result, a snapshot of the display pins plus idle and rejected
// flags, taken after the item. Requests that arrive while a sequence runs are
// refused and flagged; ticks advance the running sequence. One item is taken
// per clock and one result leaves per clock in steady state while pop stays
// high: an item is registered in the two-entry front queue, is executed by
// the sequencer once it is at the queue head and the result queue has room,
// and its result is registered in the two-entry result queue. The
// sequencer's per-item phase and counter update sets that rate. full only
// depends on the front queue, so pushes keep flowing while a finished result
// waits for pop. Configuration writes are always ready and should be made
// while no item is in flight.

module char_lcd_4bit_interface_core import lcd4_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item side
    input  logic                       push,
    input  t_in_item                   i_in_item,
    output logic                       full,
    // result side
    output logic                       empty,
    input  logic                       pop,
    output t_out_item                  o_out_item,
    // config write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    t_work_item w_item;
    logic       w_item_valid;
    logic       w_take;
    t_cfg_wr    w_cfg;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // a config transfer completes on any valid cycle
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // front: decode and queue items
    lcd4_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_in_item    (i_in_item),
        .o_full       (full),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    // back: bus sequencer and result queue
    lcd4_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_empty      (empty),
        .o_out_item   (o_out_item),
        .i_pop        (pop)
    );

endmodule

FILE: rtl/lcd4_checker.sv
// port-level checks for the lcd controller, bound to the top level
`timescale 1ns / 1ps

module lcd4_checker import lcd4_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       empty,
    input logic                       pop,
    input t_out_item                  o_out_item
);

    // a refused request leaves the running sequence busy
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.rejected) |-> !o_out_item.idle)
        else $error("rejected result reports idle");

    // reading only with the bus released and register select on command
    a_read_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.pin_read_write) |->
            (!o_out_item.drive_bus && !o_out_item.pin_select))
        else $error("read while driving the bus or with data select");

    // no strobe left high once a sequence is over
    a_idle_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.idle) |-> !o_out_item.pin_enable)
        else $error("enable high while idle");

    // a waiting result holds until its transfer
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or vanished");

endmodule

bind char_lcd_4bit_interface_core lcd4_checker u_lcd4_checker (.*);

FILE: dv/lcd4_tb_pkg.sv
// pin predictor and result scoreboard for the lcd controller testbench
`timescale 1ns / 1ps

package lcd4_tb_pkg;

    import lcd4_pkg::*;

    // bytes sent after the nibble part of power-up
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;

    class lcd_pin_predictor;

        // register copies
        logic                   busy_poll;
        logic [7:0]             strobe_len;
        logic [15:0]            settle_len;
        logic [15:0]            power_up_len;
        logic [15:0]            gap_long_len;
        logic [15:0]            gap_short_len;
        logic [15:0]            clear_len;

        // sequencer copy
        t_phase                 ph;
        logic [COUNT_WIDTH-1:0] count;
        logic [7:0]             byte_q;
        logic                   sel_q;
        logic [3:0]             step_q;
        logic                   en_q;
        logic                   rd_q;
        logic [3:0]             nib_q;
        logic                   drive_q;
        logic                   busy_q;

        t_out_item              expected_pins[$];
        int                     mismatches;

        function new();
            busy_poll     = 1'b0;
            strobe_len    = 8'd1;
            settle_len    = 16'd60;
            power_up_len  = 16'd15000;
            gap_long_len  = 16'd5000;
            gap_short_len = 16'd1000;
            clear_len     = 16'd1600;
            ph            = PH_IDLE;
            count         = '0;
            byte_q        = '0;
            sel_q         = 1'b0;
            step_q        = '0;
            en_q          = 1'b0;
            rd_q          = 1'b0;
            nib_q         = '0;
            drive_q       = 1'b1;
            busy_q        = 1'b0;
            mismatches    = 0;
        endfunction

        function void note_setting(t_cfg_reg r, logic [15:0] v);
            case (r)
                CFG_BUSY_CHECK: busy_poll     = v[0];
                CFG_STROBE:     strobe_len    = v[7:0];
                CFG_SETTLE:     settle_len    = v;
                CFG_POWER_UP:   power_up_len  = v;
                CFG_GAP_LONG:   gap_long_len  = v;
                CFG_GAP_SHORT:  gap_short_len = v;
                CFG_CLEAR_WAIT: clear_len     = v;
                default: ;
            endcase
        endfunction

        function bit lcd_idle();
            return ph == PH_IDLE;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        // counts clip at the counter top
        function void load(logic [15:0] n);
            if (32'(n) > 32'(COUNT_MAX)) begin
                count = COUNT_MAX;
            end else begin
                count = COUNT_WIDTH'(n);
            end
        endfunction

        // true on the tick that ends a wait or strobe
        function bit count_done();
            if (count <= 1) begin
                count = '0;
                return 1'b1;
            end
            count = count - 1'b1;
            return 1'b0;
        endfunction

        function void start_strobe(t_phase nxt);
            en_q = 1'b1;
            load({8'd0, strobe_len});
            ph = nxt;
        endfunction

        function void start_byte();
            nib_q = byte_q[7:4];
            start_strobe(PH_HI_STROBE);
        endfunction

        function void begin_wait();
            en_q = 1'b0;
            if (busy_poll) begin
                drive_q = 1'b0;
                rd_q    = 1'b1;
                sel_q   = 1'b0;
                busy_q  = 1'b1;
                ph      = PH_POLL_LOW2;
            end else begin
                load(settle_len);
                ph = PH_SETTLE;
            end
        endfunction

        function void after_wait();
            if (step_q >= 4) begin
                // clear was the last power-up byte
                if (step_q >= 7) begin
                    step_q = '0;
                    if (!busy_poll) begin
                        load(clear_len);
                        ph = PH_CLEAR;
                    end else begin
                        ph = PH_IDLE;
                    end
                    return;
                end
                step_q = step_q + 1'b1;
                case (step_q)
                    4'd5:    byte_q = CMD_DISPLAY_ON;
                    4'd6:    byte_q = CMD_ENTRY_MODE;
                    default: byte_q = CMD_CLEAR;
                endcase
                sel_q = 1'b0;
            end else begin
                sel_q = step_q[0];
            end
            rd_q = 1'b0;
            start_byte();
        endfunction

        function void advance_tick(logic bp);
            case (ph)
                PH_POWER: if (count_done()) begin
                    nib_q = NIB_INIT_EIGHT;
                    start_strobe(PH_INIT_STROBE);
                end
                PH_INIT_STROBE: if (count_done()) begin
                    en_q = 1'b0;
                    load(step_q == 0 ? gap_long_len : gap_short_len);
                    ph = PH_INIT_WAIT;
                end
                PH_INIT_WAIT: if (count_done()) begin
                    step_q = step_q + 1'b1;
                    if (step_q < 4) begin
                        nib_q = (step_q == 3) ? NIB_INIT_FOUR : NIB_INIT_EIGHT;
                        start_strobe(PH_INIT_STROBE);
                    end else begin
                        step_q = 4'd4;
                        byte_q = CMD_FUNCTION_SET;
                        sel_q  = 1'b0;
                        start_byte();
                    end
                end
                PH_SETTLE: if (count_done()) after_wait();
                PH_POLL_HIGH1: if (count_done()) begin
                    busy_q = bp;
                    en_q   = 1'b0;
                    ph     = PH_POLL_LOW1;
                end
                PH_POLL_LOW1: start_strobe(PH_POLL_HIGH2);
                PH_POLL_HIGH2: if (count_done()) begin
                    en_q = 1'b0;
                    ph   = PH_POLL_LOW2;
                end
                PH_POLL_LOW2: begin
                    if (busy_q) begin
                        start_strobe(PH_POLL_HIGH1);
                    end else begin
                        drive_q = 1'b1;
                        rd_q    = 1'b0;
                        after_wait();
                    end
                end
                PH_HI_STROBE: if (count_done()) begin
                    en_q  = 1'b0;
                    nib_q = byte_q[3:0];
                    ph    = PH_NIB_GAP;
                end
                PH_NIB_GAP: start_strobe(PH_LO_STROBE);
                PH_LO_STROBE: if (count_done()) begin
                    en_q = 1'b0;
                    if (step_q >= 4) begin
                        begin_wait();
                    end else begin
                        ph = PH_IDLE;
                    end
                end
                PH_CLEAR: if (count_done()) ph = PH_IDLE;
                default: ph = PH_IDLE;
            endcase
        endfunction

        // accepted input: advance the copy and queue the pins it leaves
        function void note_item(t_in_item it);
            t_out_item want;
            logic      refused;
            refused = 1'b0;
            if (it.operation == OP_TICK) begin
                advance_tick(it.busy_pin);
            end else if (ph != PH_IDLE) begin
                refused = 1'b1;
            end else if (it.operation == OP_INIT) begin
                en_q    = 1'b0;
                sel_q   = 1'b0;
                rd_q    = 1'b0;
                drive_q = 1'b1;
                step_q  = '0;
                load(power_up_len);
                ph = PH_POWER;
            end else begin
                byte_q  = it.byte_value;
                step_q  = (it.operation == OP_DATA) ? 4'd1 : 4'd0;
                sel_q   = 1'b0;
                rd_q    = 1'b0;
                drive_q = 1'b1;
                begin_wait();
            end
            want.pin_enable     = en_q;
            want.pin_select     = sel_q;
            want.pin_read_write = rd_q;
            want.pin_nibble     = nib_q;
            want.drive_bus      = drive_q;
            want.idle           = (ph == PH_IDLE);
            want.rejected       = refused;
            expected_pins.push_back(want);
        endfunction

        function void check_pins(t_out_item got);
            t_out_item want;
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: got %p", got);
                end
                return;
            end
            want = expected_pins.pop_front();
            if (got.pin_enable     !== want.pin_enable     ||
                got.pin_select     !== want.pin_select     ||
                got.pin_read_write !== want.pin_read_write ||
                got.pin_nibble     !== want.pin_nibble     ||
                got.drive_bus      !== want.drive_bus      ||
                got.idle           !== want.idle           ||
                got.rejected       !== want.rejected) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("pin mismatch: expected %p got %p", want, got);
                end
            end
        endfunction

    endclass

endpackage

FILE: dv/tb.sv
// self-checking testbench for the 4-bit character lcd controller
`timescale 1ns / 1ps

module tb;

    import lcd4_pkg::*;
    import lcd4_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 8;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       push        = 1'b0;
    t_in_item                   in_item     = '0;
    logic                       full;
    logic                       empty;
    logic                       pop         = 1'b0;
    t_out_item                  out_item;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data  = '0;

    lcd_pin_predictor pins;
    int               items_sent = 0;
    int               cycles     = 0;
    // both sides stop idling while this is set
    bit               no_gaps    = 1'b0;

    char_lcd_4bit_interface_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("char_lcd_4bit_interface_core regression: fail");
        $finish;
    end

    // result side: signals read right after the edge still hold their pre-edge
    // values, so a transfer is exactly what the dut saw at that edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && !empty && pop) begin
                pins.check_pins(out_item);
            end
            pop <= no_gaps || ($urandom_range(99) >= 12);
        end
    end

    function automatic t_in_item make_item(t_op op, logic [7:0] b, logic bp);
        t_in_item it;
        it.operation  = op;
        it.byte_value = b;
        it.busy_pin   = bp;
        return it;
    endfunction

    function automatic t_op random_request();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            return OP_INIT;
        end
        if (r < 57) begin
            return OP_CMD;
        end
        return OP_DATA;
    endfunction

    // one input transfer; push stays high so the next item can follow at once
    task automatic send_item(t_in_item it);
        if (!no_gaps && $urandom_range(99) < 8) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pins.note_item(it);
        items_sent++;
    endtask

    // tick the running sequence to its end, with optional rejected requests
    task automatic finish_sequence(int busy_pct, int noise_pct);
        while (!pins.lcd_idle()) begin
            if ($urandom_range(99) < noise_pct) begin
                send_item(make_item(random_request(), 8'($urandom), 1'($urandom_range(1))));
            end else begin
                send_item(make_item(OP_TICK, 8'($urandom),
                                    1'($urandom_range(99) < busy_pct)));
            end
        end
    endtask

    task automatic run_sequence();
        if ($urandom_range(99) < 5) begin
            // stray tick while idle, ignored by the block
            send_item(make_item(OP_TICK, 8'($urandom), 1'($urandom_range(1))));
        end else begin
            send_item(make_item(random_request(), 8'($urandom), 1'($urandom_range(1))));
            finish_sequence(35, 5);
        end
    endtask

    // valid is left high so back-to-back writes need no extra edge
    task automatic cfg_write(t_cfg_reg r, logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pins.note_setting(r, v);
    endtask

    // sender holds off until every result is back, then rewrites all registers
    task automatic apply_settings(logic busy, logic [15:0] strobe, logic [15:0] settle,
                                  logic [15:0] power, logic [15:0] glong,
                                  logic [15:0] gshort, logic [15:0] clr);
        push <= 1'b0;
        while (pins.pending() != 0) @(posedge i_clk);
        cfg_write(CFG_BUSY_CHECK, {15'd0, busy});
        cfg_write(CFG_STROBE, strobe);
        cfg_write(CFG_SETTLE, settle);
        cfg_write(CFG_POWER_UP, power);
        cfg_write(CFG_GAP_LONG, glong);
        cfg_write(CFG_GAP_SHORT, gshort);
        cfg_write(CFG_CLEAR_WAIT, clr);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int start;
        pins = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fixed waits, every timing at its minimum
        apply_settings(1'b0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(make_item(OP_TICK, 8'hFF, 1'b1));
        send_item(make_item(OP_CMD, 8'h00, 1'b0));
        // requests while a byte is going out are refused
        send_item(make_item(OP_DATA, 8'hFF, 1'b1));
        send_item(make_item(OP_INIT, 8'h00, 1'b0));
        send_item(make_item(OP_CMD, 8'h5A, 1'b1));
        finish_sequence(50, 0);
        send_item(make_item(OP_DATA, 8'hFF, 1'b1));
        finish_sequence(50, 0);
        send_item(make_item(OP_INIT, 8'hA5, 1'b0));
        finish_sequence(50, 0);

        // busy-flag polling, clear wait at its maximum but unused in this mode
        apply_settings(1'b1, 16'd2, 16'd3, 16'd2, 16'd1, 16'd1, 16'hFFFF);
        send_item(make_item(OP_DATA, 8'hA5, 1'b0));
        finish_sequence(60, 0);
        send_item(make_item(OP_CMD, 8'h5A, 1'b1));
        finish_sequence(0, 0);
        send_item(make_item(OP_INIT, 8'h3C, 1'b1));
        finish_sequence(30, 0);

        // longest strobe, short settle time, other timing registers at the top;
        // one byte only, sent with no idling on either side
        apply_settings(1'b0, 16'd255, 16'd40, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        no_gaps = 1'b1;
        send_item(make_item(OP_DATA, 8'hC3, 1'b1));
        finish_sequence(50, 0);
        no_gaps = 1'b0;

        // random phases: short timings, well-formed sequences with some noise
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            apply_settings(1'($urandom_range(1)), 16'($urandom_range(1, 3)),
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 5)), 16'($urandom_range(0, 4)),
                           16'($urandom_range(0, 6)));
            repeat ($urandom_range(3, 8)) run_sequence();
        end

        push <= 1'b0;
        while (pins.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pins.mismatches == 0 && pins.pending() == 0) begin
            $display("char_lcd_4bit_interface_core regression: pass");
        end else begin
            $display("char_lcd_4bit_interface_core regression: fail");
        end
        $finish;
    end

endmodule
